// ----- src/vtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared types and constants for the vertex transform and divide core.
// ----------------------------------------------------------------------------
package vtd_pkg;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  localparam int NUM_COEF = 16;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic               kind;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } vtd_in_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic               w_was_zero;
    logic               saturated;
  } vtd_out_t;

  // scaled products (index row*4+column, rows 0..2) and the translation row
  typedef struct packed {
    logic [11:0][63:0] prod;
    logic [3:0][31:0]  trans;
  } vtd_work_t;

  // handshake pair between front and queue, queue and back
  typedef struct packed {
    logic valid;
    logic ready;
  } vtd_hs_t;

endpackage

// ----- src/vtd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_front
// Accepts transactions, writes matrix loads, forms the scaled products of
// each vertex in one registered stage.
// ----------------------------------------------------------------------------
module vtd_front
  import vtd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vtd_in_t   in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output vtd_work_t push_data
);

  logic signed [31:0] coef_r [NUM_COEF];
  logic               st_valid_r;
  vtd_work_t          st_data_r;
  vtd_work_t          st_data_nxt;
  logic               acc;
  logic signed [31:0] pv [3];
  logic signed [63:0] full;

  assign in_ready   = !st_valid_r || push_ready;
  assign acc        = in_valid && in_ready;
  assign push_valid = st_valid_r;
  assign push_data  = st_data_r;

  assign pv[0] = in_data.px;
  assign pv[1] = in_data.py;
  assign pv[2] = in_data.pz;

  // matrix store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
    end else if (acc && in_data.kind == KIND_LOAD) begin
      coef_r[in_data.coef_index] <= in_data.coef_value;
    end
  end

  // products, floored by the arithmetic shift
  always_comb begin
    full = '0;
    st_data_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        full = pv[r] * coef_r[r * 4 + c];
        st_data_nxt.prod[r * 4 + c] = full >>> FRAC_BITS;
      end
    end
    for (int c = 0; c < 4; c++) st_data_nxt.trans[c] = coef_r[12 + c];
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= acc && in_data.kind == KIND_VERTEX;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && acc) begin
      st_data_r <= st_data_nxt;
    end
  end

endmodule

// ----- src/vtd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module vtd_fifo
  import vtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  vtd_work_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output vtd_work_t pop_data
);

  vtd_work_t  mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- src/vtd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_back
// Sums and saturates the columns, then divides x, y, z by w in a pipelined
// restoring divider, one quotient bit per stage (undivided sums when w is zero).
// ----------------------------------------------------------------------------
module vtd_back
  import vtd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  vtd_work_t pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output vtd_out_t  out_data
);

  localparam int DW = 32 + FRAC_BITS;
  localparam logic [DW-1:0] POS_LIM = DW'(33'h0_7FFF_FFFF);
  localparam logic [DW-1:0] NEG_LIM = DW'(33'h0_8000_0000);

  logic     out_valid_r;
  vtd_out_t out_data_r;

  logic en;
  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;

  // sum stage
  logic               a_valid_r;
  logic signed [31:0] a_s_r [4];
  logic               a_sat_r;
  logic signed [63:0] sum [4];
  logic [3:0]         sum_hi;
  logic [3:0]         sum_lo;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = 64'(signed'(pop_data.trans[c])) + signed'(pop_data.prod[c])
             + signed'(pop_data.prod[4 + c]) + signed'(pop_data.prod[8 + c]);
      sum_hi[c] = sum[c] > S32_MAX;
      sum_lo[c] = sum[c] < S32_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        priority if (sum_hi[c]) a_s_r[c] <= 32'sh7FFF_FFFF;
        else if (sum_lo[c])     a_s_r[c] <= 32'sh8000_0000;
        else                    a_s_r[c] <= sum[c][31:0];
      end
      a_sat_r <= |(sum_hi | sum_lo);
    end
  end

  // divider pipeline, entry DW is the last
  logic              v_r   [DW+1];
  logic [31:0]       rem_r [DW+1][3];
  logic [DW-1:0]     dvd_r [DW+1][3];
  logic [DW-1:0]     q_r   [DW+1][3];
  logic [31:0]       dsr_r [DW+1];
  logic [2:0]        neg_r [DW+1];
  logic [2:0][31:0]  s_r   [DW+1];
  logic              wz_r  [DW+1];
  logic              sat_r [DW+1];
  logic [31:0]       w_mag;

  assign w_mag = a_s_r[3][31] ? 32'(-a_s_r[3]) : 32'(a_s_r[3]);

  // setup: magnitudes and signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[0][c] <= '0;
        q_r[0][c]   <= '0;
        dvd_r[0][c] <= {(a_s_r[c][31] ? 32'(-a_s_r[c]) : 32'(a_s_r[c])),
                        {FRAC_BITS{1'b0}}};
        neg_r[0][c] <= a_s_r[c][31] ^ a_s_r[3][31];
        s_r[0][c]   <= a_s_r[c];
      end
      dsr_r[0] <= w_mag;
      wz_r[0]  <= a_s_r[3] == 32'sd0;
      sat_r[0] <= a_sat_r;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [32:0]   trial [3];
    logic [2:0]    qbit;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = {rem_r[k][c], dvd_r[k][c][DW-1]};
        qbit[c]  = trial[c] >= {1'b0, dsr_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          rem_r[k+1][c] <= qbit[c] ? 32'(trial[c] - {1'b0, dsr_r[k]}) : trial[c][31:0];
          dvd_r[k+1][c] <= dvd_r[k][c] << 1;
          q_r[k+1][c]   <= {q_r[k][c][DW-2:0], qbit[c]};
        end
        dsr_r[k+1] <= dsr_r[k];
        neg_r[k+1] <= neg_r[k];
        s_r[k+1]   <= s_r[k];
        wz_r[k+1]  <= wz_r[k];
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  // sign, clamp and select the undivided sums when w is zero
  logic [2:0][31:0] quo;
  logic [2:0]       qsat;
  vtd_out_t         res;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (neg_r[DW][c]) begin
        qsat[c] = q_r[DW][c] > NEG_LIM;
        quo[c]  = qsat[c] ? 32'h8000_0000 : 32'(-q_r[DW][c][31:0]);
      end else begin
        qsat[c] = q_r[DW][c] > POS_LIM;
        quo[c]  = qsat[c] ? 32'h7FFF_FFFF : q_r[DW][c][31:0];
      end
    end
    if (wz_r[DW]) begin
      res.ox = s_r[DW][0];
      res.oy = s_r[DW][1];
      res.oz = s_r[DW][2];
    end else begin
      res.ox = quo[0];
      res.oy = quo[1];
      res.oz = quo[2];
    end
    res.w_was_zero = wz_r[DW];
    res.saturated  = sat_r[DW] || (!wz_r[DW] && (|qsat));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/vertex_transform_divide_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_divide_core
// 4x4 homogeneous vertex transform with perspective divide, signed fixed
// point, saturating.
// ----------------------------------------------------------------------------
//  channel | ports                         | carries
//  --------+-------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data   | coefficient load or vertex
//  out     | out_valid, out_ready, out_data| transformed vertex and flags
//
// one transaction per cycle sustained while the output is not stalled; a
// vertex passes the product, queue, sum, setup, divider (32 + FRAC_BITS
// stages) and output registers. loads take effect at acceptance and give no
// result. reset (synchronous, active low) clears the matrix to zero and
// empties the pipeline. a stalled output freezes the back pipeline; the
// two-entry queue lets the front keep accepting until it fills.
// ----------------------------------------------------------------------------
module vertex_transform_divide_core
  import vtd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vtd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vtd_out_t out_data
);

  vtd_hs_t   fq_hs;
  vtd_hs_t   qb_hs;
  vtd_work_t fq_data;
  vtd_work_t qb_data;

  // front: loads and products
  vtd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (fq_hs.valid),
    .push_ready (fq_hs.ready),
    .push_data  (fq_data)
  );

  // queue
  vtd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_hs.valid),
    .push_ready (fq_hs.ready),
    .push_data  (fq_data),
    .pop_valid  (qb_hs.valid),
    .pop_ready  (qb_hs.ready),
    .pop_data   (qb_data)
  );

  // back: sums and divide
  vtd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (qb_hs.valid),
    .pop_ready  (qb_hs.ready),
    .pop_data   (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // front only stalls on a full queue
  a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (fq_hs.valid && !fq_hs.ready))
    else $error("front stalled without a full queue");

  // a full queue always has something to give
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_hs.valid && !fq_hs.ready) |-> qb_hs.valid)
    else $error("queue full and empty at once");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule
